// ===== hdl/dtc_pkg.sv =====
// ----------------------------------------------------------------------------
// dtc_pkg
// Shared types and constants of the device table with compaction.
// ----------------------------------------------------------------------------
package dtc_pkg;

  localparam int MAX_ENTRIES_DEF = 8;

  localparam int OP_W    = 3;
  localparam int ST_W    = 3;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int SHORT_W = 16;
  localparam int LONG_W  = 64;
  localparam int TIME_W  = 32;

  localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd1000;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_READ   = 3'd2,
    OP_FIND   = 3'd3,
    OP_SWEEP  = 3'd4,
    OP_REACT  = 3'd5
  } opcode_e;

  typedef enum logic [ST_W-1:0] {
    ST_ADDED    = 3'd0,
    ST_REACT    = 3'd1,
    ST_DUP      = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_OK       = 3'd5,
    ST_MARKED   = 3'd6,
    ST_DONE     = 3'd7
  } status_e;

  typedef struct packed {
    logic [SHORT_W-1:0] short_addr;
    logic [LONG_W-1:0]  long_addr;
    logic               active;
    logic [TIME_W-1:0]  stamp;
  } entry_t;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [SHORT_W-1:0] short_addr;
    logic [LONG_W-1:0]  long_addr;
    logic               match_by_short;
    logic [IDX_W-1:0]   entry_index;
    logic [TIME_W-1:0]  now;
  } req_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    status_e            status;
    logic [IDX_W-1:0]   result_index;
    logic [SHORT_W-1:0] result_short;
    logic [LONG_W-1:0]  result_long;
    logic               result_active;
    logic [CNT_W-1:0]   entry_count;
    logic               last_of_run;
  } res_t;

endpackage

// ===== hdl/dtc_mem.sv =====
// ----------------------------------------------------------------------------
// dtc_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dtc_mem #(
  parameter int DEPTH = dtc_pkg::MAX_ENTRIES_DEF
) (
  input  logic              clk_i,
  input  dtc_pkg::mem_req_t req_i,
  output dtc_pkg::entry_t   rdata_o
);
  import dtc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr[AW-1:0]] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr[AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/dtc_out_reg.sv =====
// ----------------------------------------------------------------------------
// dtc_out_reg
// Result holding register between the sequencer and the output stream.
// ----------------------------------------------------------------------------
module dtc_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dtc_pkg::res_t data_i,
  input  logic          ready_i,
  output logic          valid_o,
  output dtc_pkg::res_t data_o,
  output logic          free_o
);
  import dtc_pkg::*;

  logic valid_q, valid_d;
  res_t data_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = push_i ? 1'b1 : (ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hdl/dtc_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtc_ctrl
// Sequencer: walks the entry store, read-modify-write, compaction on remove.
// ----------------------------------------------------------------------------
module dtc_ctrl #(
  parameter int MAX_ENTRIES = dtc_pkg::MAX_ENTRIES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  dtc_pkg::req_t                    in_req_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [dtc_pkg::TIME_W-1:0]       cfg_data_i,
  output dtc_pkg::mem_req_t                mem_req_o,
  input  dtc_pkg::entry_t                  mem_rdata_i,
  input  logic                             out_free_i,
  output logic                             out_push_o,
  output dtc_pkg::res_t                    out_data_o
);
  import dtc_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_CHK, S_END, S_EMIT, S_SH_RD, S_SH_WR
  } state_e;

  state_e            state_q, ret_q;
  req_t              req_q;
  logic [CW-1:0]     cnt_q, fill_q;
  logic [TIME_W-1:0] timeout_q;
  res_t              res_q;

  logic [CW-1:0]     cnt_inc;
  logic [TIME_W-1:0] idle;
  logic              short_eq, long_eq, hit;
  opcode_e           op, in_op;
  entry_t            shown;

  function automatic res_t entry_res(status_e st, entry_t e, logic [AW-1:0] pos,
                                     logic [CW-1:0] cnt, logic last);
    res_t r;
    r.status        = st;
    r.result_index  = IDX_W'(pos);
    r.result_short  = e.short_addr;
    r.result_long   = e.long_addr;
    r.result_active = e.active;
    r.entry_count   = CNT_W'(cnt);
    r.last_of_run   = last;
    return r;
  endfunction

  function automatic res_t empty_res(status_e st, logic [CW-1:0] cnt);
    res_t r;
    r               = '0;
    r.status        = st;
    r.entry_count   = CNT_W'(cnt);
    r.last_of_run   = 1'b1;
    return r;
  endfunction

  assign op       = opcode_e'(req_q.opcode);
  assign in_op    = opcode_e'(in_req_i.opcode);
  assign cnt_inc  = cnt_q + 1'b1;
  assign idle     = req_q.now - mem_rdata_i.stamp;
  assign short_eq = mem_rdata_i.short_addr == req_q.short_addr;
  assign long_eq  = mem_rdata_i.long_addr == req_q.long_addr;

  assign in_ready_o  = state_q == S_IDLE;
  assign cfg_ready_o = 1'b1;
  assign out_push_o  = (state_q == S_EMIT) && out_free_i;
  assign out_data_o  = res_q;

  always_comb begin
    case (op)
      OP_ADD:   hit = req_q.match_by_short ? short_eq : long_eq;
      OP_FIND:  hit = short_eq;
      OP_REACT: hit = short_eq;
      OP_SWEEP: hit = mem_rdata_i.active && (idle > timeout_q);
      default:  hit = 1'b1;
    endcase
  end

  always_comb begin
    mem_req_o = '0;
    case (state_q)
      S_RD: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = IDX_W'(cnt_q[AW-1:0]);
      end
      S_CHK: begin
        mem_req_o.waddr = IDX_W'(cnt_q[AW-1:0]);
        mem_req_o.wdata = mem_rdata_i;
        if (hit) begin
          case (op)
            OP_ADD: begin
              if (req_q.match_by_short && !mem_rdata_i.active) begin
                mem_req_o.we           = 1'b1;
                mem_req_o.wdata.active = 1'b1;
                mem_req_o.wdata.stamp  = req_q.now;
              end
            end
            OP_REACT: begin
              mem_req_o.we           = 1'b1;
              mem_req_o.wdata.active = 1'b1;
            end
            OP_SWEEP: begin
              mem_req_o.we           = 1'b1;
              mem_req_o.wdata.active = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_END: begin
        mem_req_o.waddr            = IDX_W'(fill_q[AW-1:0]);
        mem_req_o.wdata.short_addr = req_q.short_addr;
        mem_req_o.wdata.long_addr  = req_q.long_addr;
        mem_req_o.wdata.active     = 1'b1;
        mem_req_o.wdata.stamp      = req_q.now;
        mem_req_o.we               = (op == OP_ADD) && (fill_q < MAX_CNT);
      end
      S_SH_RD: begin
        mem_req_o.re    = cnt_q < fill_q;
        mem_req_o.raddr = IDX_W'(cnt_inc[AW-1:0]);
      end
      S_SH_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = IDX_W'(cnt_q[AW-1:0]);
        mem_req_o.wdata = mem_rdata_i;
      end
      default: ;
    endcase
  end

  assign shown = mem_req_o.we ? mem_req_o.wdata : mem_rdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ret_q     <= S_IDLE;
      req_q     <= '0;
      res_q     <= '0;
      cnt_q     <= '0;
      fill_q    <= '0;
      timeout_q <= TIMEOUT_RST;
    end else begin
      if (cfg_valid_i) begin
        timeout_q <= cfg_data_i;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q <= in_req_i;
            cnt_q <= '0;
            ret_q <= S_IDLE;
            case (in_op)
              OP_ADD, OP_FIND, OP_REACT, OP_SWEEP: begin
                state_q <= (fill_q == '0) ? S_END : S_RD;
              end
              OP_REMOVE, OP_READ: begin
                if ({1'b0, in_req_i.entry_index} >= CNT_W'(fill_q)) begin
                  res_q   <= empty_res(ST_NOTFOUND, fill_q);
                  state_q <= S_EMIT;
                end else begin
                  cnt_q   <= CW'(in_req_i.entry_index);
                  state_q <= S_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_RD: begin
          state_q <= S_CHK;
        end
        S_CHK: begin
          case (op)
            OP_REMOVE: begin
              res_q   <= entry_res(ST_OK, mem_rdata_i, cnt_q[AW-1:0], fill_q - 1'b1, 1'b1);
              fill_q  <= fill_q - 1'b1;
              ret_q   <= S_SH_RD;
              state_q <= S_EMIT;
            end
            OP_READ: begin
              res_q   <= entry_res(ST_OK, mem_rdata_i, cnt_q[AW-1:0], fill_q, 1'b1);
              state_q <= S_EMIT;
            end
            OP_SWEEP: begin
              cnt_q <= cnt_inc;
              if (hit) begin
                res_q   <= entry_res(ST_MARKED, mem_rdata_i, cnt_q[AW-1:0], fill_q, 1'b0);
                ret_q   <= (cnt_inc < fill_q) ? S_RD : S_END;
                state_q <= S_EMIT;
              end else begin
                state_q <= (cnt_inc < fill_q) ? S_RD : S_END;
              end
            end
            default: begin
              if (hit) begin
                if (op == OP_ADD) begin
                  res_q <= entry_res(mem_req_o.we ? ST_REACT : ST_DUP, shown,
                                     cnt_q[AW-1:0], fill_q, 1'b1);
                end else begin
                  res_q <= entry_res(ST_OK, shown, cnt_q[AW-1:0], fill_q, 1'b1);
                end
                state_q <= S_EMIT;
              end else if (cnt_inc < fill_q) begin
                cnt_q   <= cnt_inc;
                state_q <= S_RD;
              end else begin
                state_q <= S_END;
              end
            end
          endcase
        end
        S_END: begin
          ret_q   <= S_IDLE;
          state_q <= S_EMIT;
          case (op)
            OP_ADD: begin
              if (fill_q >= MAX_CNT) begin
                res_q <= empty_res(ST_FULL, fill_q);
              end else begin
                res_q  <= entry_res(ST_ADDED, mem_req_o.wdata, fill_q[AW-1:0],
                                    fill_q + 1'b1, 1'b1);
                fill_q <= fill_q + 1'b1;
              end
            end
            OP_SWEEP: res_q <= empty_res(ST_DONE, fill_q);
            default:  res_q <= empty_res(ST_NOTFOUND, fill_q);
          endcase
        end
        S_EMIT: begin
          if (out_free_i) begin
            state_q <= ret_q;
          end
        end
        S_SH_RD: begin
          state_q <= (cnt_q < fill_q) ? S_SH_WR : S_IDLE;
        end
        S_SH_WR: begin
          cnt_q   <= cnt_inc;
          state_q <= S_SH_RD;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/device_table_with_compaction_top.sv =====
// ----------------------------------------------------------------------------
// device_table_with_compaction_top
// Peer device table with duplicate check, compaction and idle sweep.
// ----------------------------------------------------------------------------
// One request is handled at a time. The entries live in a memory with one
// write port and one read port with registered read data, and every entry
// visited is first read, then checked or written back. Add, find and
// reactivate scan the stored entries until one hits; read visits the
// indexed entry; remove visits it and then shifts every entry above it down
// by one; an out-of-range read or remove visits no entry; sweep visits every
// stored entry and reports each one that it marks inactive. Each result beat
// waits until the output register is free. A finished result is held in an
// output register, so the next request is taken while it waits.
module device_table_with_compaction_top #(
  parameter int MAX_ENTRIES = dtc_pkg::MAX_ENTRIES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // short_addr[15:0], long_addr[79:16], entry_index[85:80], now[117:86], zero
  input  logic [119:0] s_axis_tdata,
  // opcode[2:0], match_by_short[3]
  input  logic [3:0]   s_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [31:0]  cfg_data_i,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_index[5:0], result_short[21:6], result_long[85:22],
  // result_active[86], entry_count[93:87], zero
  output logic [95:0]  m_axis_tdata,
  // status[2:0]
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast
);
  import dtc_pkg::*;

  req_t     req;
  mem_req_t mem_req;
  entry_t   mem_rdata;
  res_t     push_data, out_data;
  logic     out_free, out_push;

  assign req.opcode         = s_axis_tuser[2:0];
  assign req.match_by_short = s_axis_tuser[3];
  assign req.short_addr     = s_axis_tdata[15:0];
  assign req.long_addr      = s_axis_tdata[79:16];
  assign req.entry_index    = s_axis_tdata[85:80];
  assign req.now            = s_axis_tdata[117:86];

  dtc_ctrl #(.MAX_ENTRIES(MAX_ENTRIES)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_req_i    (req),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .out_free_i  (out_free),
    .out_push_o  (out_push),
    .out_data_o  (push_data)
  );

  dtc_mem #(.DEPTH(MAX_ENTRIES)) u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  dtc_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (push_data),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .data_o  (out_data),
    .free_o  (out_free)
  );

  assign m_axis_tdata = {2'b00, out_data.entry_count, out_data.result_active,
                         out_data.result_long, out_data.result_short,
                         out_data.result_index};
  assign m_axis_tuser = out_data.status;
  assign m_axis_tlast = out_data.last_of_run;

endmodule

// ===== hdl/dtc_checker.sv =====
// ----------------------------------------------------------------------------
// dtc_checker
// Port-level checks on the result stream of the device table.
// ----------------------------------------------------------------------------
module dtc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import dtc_pkg::*;

  a_last_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != ST_MARKED)))
    else $error("tlast does not match result kind");

  a_empty_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_NOTFOUND || m_axis_tuser == ST_FULL ||
                      m_axis_tuser == ST_DONE)
    |-> (m_axis_tdata[86:0] == '0))
    else $error("entry fields not zero on empty result");

  a_active_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_ADDED || m_axis_tuser == ST_REACT ||
                      m_axis_tuser == ST_MARKED)
    |-> m_axis_tdata[86])
    else $error("entry shown inactive");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready
    |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
        $stable(m_axis_tlast))
    else $error("stalled result beat changed");

endmodule

bind device_table_with_compaction_top dtc_checker u_dtc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
